[hw/rtl/pwsd_pkg.sv]
// Shared types and event codes for the plot word stream decoder.
package pwsd_pkg;

  localparam int WordW  = 36;
  localparam int PosW   = 17;
  localparam int CharW  = 7;
  localparam int EventW = 4;
  localparam int NChars = 5;
  // Slots per job: one closing event, one main event, five characters.
  localparam int NSlots = 7;
  localparam int SlotW  = 3;

  localparam logic [EventW-1:0] EV_LINE_BEGIN = 4'd0;
  localparam logic [EventW-1:0] EV_LINE_POINT = 4'd1;
  localparam logic [EventW-1:0] EV_LINE_END   = 4'd2;
  localparam logic [EventW-1:0] EV_TEXT_BEGIN = 4'd3;
  localparam logic [EventW-1:0] EV_CHAR       = 4'd4;
  localparam logic [EventW-1:0] EV_TEXT_END   = 4'd5;
  localparam logic [EventW-1:0] EV_DONE       = 4'd6;
  localparam logic [EventW-1:0] EV_BAD_WORD   = 4'd7;
  localparam logic [EventW-1:0] EV_NOT_TEXT   = 4'd8;

  localparam logic [SlotW-1:0] SLOT_PRE   = 3'd0;
  localparam logic [SlotW-1:0] SLOT_MAIN  = 3'd1;
  localparam logic [SlotW-1:0] SLOT_CHAR0 = 3'd2;

  // One classified input item: the events it causes, in slot order.
  typedef struct packed {
    logic [NSlots-1:0]             mask;
    logic [EventW-1:0]             pre_ev;
    logic [EventW-1:0]             main_ev;
    logic                          main_pos;
    logic [PosW-1:0]               x;
    logic [PosW-1:0]               y;
    logic [NChars-1:0][CharW-1:0]  chars;
  } job_t;

endpackage

[hw/rtl/pwsd_front.sv]
// Front part: accepts plot words, tracks the parse mode and builds jobs.
module pwsd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  input  logic [35:0]   in_plot_word,
  input  logic          q_full,
  output logic          q_push,
  output pwsd_pkg::job_t q_data
);
  import pwsd_pkg::*;

  localparam logic [2:0] M_DISPATCH = 3'd0;
  localparam logic [2:0] M_LINE     = 3'd1;
  localparam logic [2:0] M_TEXT1    = 3'd2;
  localparam logic [2:0] M_TEXTC    = 3'd3;
  localparam logic [2:0] M_HALT     = 3'd4;

  localparam logic [17:0] HALT_MARK = 18'o400001;

  typedef struct packed {
    logic [EventW-1:0] ev;
    logic              pos;
    logic [2:0]        mode;
  } disp_t;

  function automatic disp_t dispatch(input logic [WordW-1:0] w);
    disp_t d;
    d.pos = 1'b0;
    if (!w[0] && !w[18]) begin
      d.ev   = EV_LINE_BEGIN;
      d.pos  = 1'b1;
      d.mode = M_LINE;
    end else if (w[18] && !w[0]) begin
      if (w[35:18] == HALT_MARK) begin
        d.ev   = EV_DONE;
        d.mode = M_HALT;
      end else begin
        d.ev   = EV_TEXT_BEGIN;
        d.pos  = 1'b1;
        d.mode = M_TEXT1;
      end
    end else begin
      d.ev   = EV_BAD_WORD;
      d.mode = M_HALT;
    end
    return d;
  endfunction

  logic [2:0] mode_r, mode_nxt;
  disp_t      d;
  job_t       job;
  logic       accept;
  integer     k;

  always_comb begin
    d        = dispatch(in_plot_word);
    mode_nxt = mode_r;
    job      = '0;
    job.x    = in_plot_word[35:19];
    job.y    = in_plot_word[17:1];
    job.chars = in_plot_word[35:1];
    case (mode_r)
      M_DISPATCH: begin
        if (in_kind) begin
          job.mask[SLOT_MAIN] = 1'b1;
          job.main_ev = EV_DONE;
          mode_nxt = M_HALT;
        end else begin
          job.mask[SLOT_MAIN] = 1'b1;
          job.main_ev  = d.ev;
          job.main_pos = d.pos;
          mode_nxt = d.mode;
        end
      end
      M_LINE, M_TEXT1, M_TEXTC: begin
        job.pre_ev = (mode_r == M_LINE) ? EV_LINE_END : EV_TEXT_END;
        if (in_kind) begin
          job.mask[SLOT_PRE]  = 1'b1;
          job.mask[SLOT_MAIN] = 1'b1;
          job.main_ev = EV_DONE;
          mode_nxt = M_HALT;
        end else if (!in_plot_word[0]) begin
          // Close the open figure, then dispatch the same word.
          job.mask[SLOT_PRE]  = 1'b1;
          job.mask[SLOT_MAIN] = 1'b1;
          job.main_ev  = d.ev;
          job.main_pos = d.pos;
          mode_nxt = d.mode;
        end else if (mode_r == M_LINE) begin
          job.mask[SLOT_MAIN] = 1'b1;
          job.main_ev  = EV_LINE_POINT;
          job.main_pos = 1'b1;
        end else if (mode_r == M_TEXT1) begin
          if (in_plot_word[35:18] != '0) begin
            job.mask[SLOT_MAIN] = 1'b1;
            job.main_ev = EV_NOT_TEXT;
            mode_nxt = M_HALT;
          end else begin
            mode_nxt = M_TEXTC;
          end
        end else begin
          // High field first; skip zero codes.
          for (k = 0; k < NChars; k++) begin
            job.mask[int'(SLOT_CHAR0) + k] = (job.chars[NChars-1-k] != '0);
          end
        end
      end
      default: begin
        mode_nxt = M_HALT;
      end
    endcase
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (job.mask != '0);
  assign q_data   = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_DISPATCH;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

[hw/rtl/pwsd_queue.sv]
// Job queue between the front and back parts.
module pwsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pwsd_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output pwsd_pkg::job_t pop_data
);
  import pwsd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  job_t            entry_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == DepthCnt);
  assign nonempty = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/pwsd_back.sv]
// Back part: walks the slots of each job and emits one event beat per cycle while the output is not stalled.
module pwsd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  pwsd_pkg::job_t            q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_event_res,
  output logic signed [16:0]        out_x_pos,
  output logic signed [16:0]        out_y_pos,
  output logic [6:0]                out_character,
  output logic                      out_last
);
  import pwsd_pkg::*;

  job_t              cur_r;
  logic              cur_valid_r, cur_valid_nxt;
  logic [NSlots-1:0] mask_r, mask_nxt;
  logic              out_valid_r;
  logic [EventW-1:0] ev_r, ev_nxt;
  logic [PosW-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [CharW-1:0]  ch_r, ch_nxt;
  logic              last_r;

  logic [SlotW-1:0]  idx;
  logic [SlotW-1:0]  char_sel;
  logic [NSlots-1:0] remaining;
  logic              adv, emit, done_cur;
  integer            i;

  // Lowest pending slot goes next.
  always_comb begin
    idx = '0;
    for (i = NSlots - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        idx = SlotW'(i);
      end
    end
  end

  assign remaining = mask_r & ~(NSlots'(1) << idx);
  assign adv       = !out_valid_r || !out_stall;
  assign emit      = adv && cur_valid_r;
  assign done_cur  = !cur_valid_r || (emit && (remaining == '0));
  assign q_pop     = q_valid && done_cur;
  assign char_sel  = SlotW'(NSlots - 1) - idx;

  always_comb begin
    ev_nxt = EV_CHAR;
    x_nxt  = '0;
    y_nxt  = '0;
    ch_nxt = '0;
    case (idx)
      SLOT_PRE: begin
        ev_nxt = cur_r.pre_ev;
      end
      SLOT_MAIN: begin
        ev_nxt = cur_r.main_ev;
        if (cur_r.main_pos) begin
          x_nxt = cur_r.x;
          y_nxt = cur_r.y;
        end
      end
      default: begin
        ch_nxt = cur_r.chars[char_sel];
      end
    endcase
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    mask_nxt      = mask_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      mask_nxt      = q_data.mask;
    end else if (done_cur) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      mask_nxt = remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (emit) begin
      ev_r   <= ev_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      ch_r   <= ch_nxt;
      last_r <= (remaining == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;
  assign out_x_pos     = $signed(x_r);
  assign out_y_pos     = $signed(y_r);
  assign out_character = ch_r;
  assign out_last      = last_r;

endmodule

[hw/rtl/plot_word_stream_decoder.sv]
// Top level of the plot word stream decoder.
//
// Input channel: in_kind (0 plot word, 1 end of input) and in_plot_word, one beat
// per accepted item. Result channel: one drawing event per beat with out_x_pos,
// out_y_pos, out_character, and out_last on the final event of each input item.
// The front part classifies each word in the cycle it is accepted and queues a
// job of up to five events; the back part sends one event per cycle while the
// receiver does not stall. With an empty queue, an accepted word passes the
// queue entry, the current-job register and the output register before its
// first event shows; words that give no event (halted, header word, empty text
// word) cost nothing at the back. in_stall rises only when the job queue
// (QUEUE_DEPTH jobs) is full. Reset puts the parser in dispatch mode and empties
// the queue and output stage. A stalled receiver holds the current event on the
// outputs; the queue keeps filling until full, then the input is stalled.
module plot_word_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [35:0]        in_plot_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_event_res,
  output logic signed [16:0] out_x_pos,
  output logic signed [16:0] out_y_pos,
  output logic [6:0]         out_character,
  output logic               out_last
);
  import pwsd_pkg::*;

  job_t push_data, pop_data;
  logic q_push, q_full, q_pop, q_nonempty;

  pwsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_plot_word (in_plot_word),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  pwsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (pop_data)
  );

  pwsd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_nonempty),
    .q_data        (pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_x_pos     (out_x_pos),
    .out_y_pos     (out_y_pos),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

[hw/rtl/pwsd_checker.sv]
// Port-level checks for the plot word stream decoder, bound to the top level.
module pwsd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         out_event_res,
  input logic signed [16:0] out_x_pos,
  input logic [6:0]         out_character,
  input logic               out_last
);
  import pwsd_pkg::*;

  // Hold a stalled beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res <= EV_NOT_TEXT)
    else $error("event code out of range");

  // Character beats carry a nonzero code and a zero x position.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_CHAR |-> out_character != '0 && out_x_pos == '0)
    else $error("malformed character event");

  // Terminal events always close the item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_DONE || out_event_res == EV_BAD_WORD ||
                  out_event_res == EV_NOT_TEXT) |-> out_last)
    else $error("terminal event not marked last");

endmodule

bind plot_word_stream_decoder pwsd_checker u_pwsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_event_res (out_event_res),
  .out_x_pos     (out_x_pos),
  .out_character (out_character),
  .out_last      (out_last)
);

[verif/pwsd_event_checker.sv]
`timescale 1ns / 1ps
// Event checker for the plot word stream decoder: predicts drawing events and compares them.
module pwsd_event_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic [35:0]        in_plot_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [3:0]         out_event_res,
  input  logic signed [16:0] out_x_pos,
  input  logic signed [16:0] out_y_pos,
  input  logic [6:0]         out_character,
  input  logic               out_last,
  input  logic               end_of_test,
  output int                 error_count,
  output int                 events_pending
);
  import pwsd_pkg::*;

  // Upper half of a text word that stops the plot instead of starting text.
  localparam logic [17:0] HALT_UPPER = 18'o400001;

  typedef enum logic [2:0] {
    MODE_DISPATCH,
    MODE_LINE,
    MODE_TEXT_HEADER,
    MODE_TEXT_CHARS,
    MODE_HALTED
  } parse_mode_t;

  typedef struct packed {
    logic [EventW-1:0] ev;
    logic [PosW-1:0]   x;
    logic [PosW-1:0]   y;
    logic [CharW-1:0]  ch;
    logic              last;
  } draw_event_t;

  parse_mode_t mode;
  draw_event_t word_events[$];
  draw_event_t expected_events[$];
  bit          tail_reported;

  initial begin
    error_count    = 0;
    events_pending = 0;
    tail_reported  = 1'b0;
    mode           = MODE_DISPATCH;
  end

  task automatic add_event(input logic [EventW-1:0] ev, input logic [WordW-1:0] w,
                           input bit with_pos, input logic [CharW-1:0] ch);
    draw_event_t e;
    e.ev   = ev;
    e.x    = with_pos ? w[35:19] : '0;
    e.y    = with_pos ? w[17:1] : '0;
    e.ch   = ch;
    e.last = 1'b0;
    word_events.push_back(e);
  endtask

  task automatic start_figure(input logic [WordW-1:0] w);
    if (!w[18] && !w[0]) begin
      add_event(EV_LINE_BEGIN, w, 1'b1, '0);
      mode = MODE_LINE;
    end else if (w[18] && !w[0]) begin
      if (w[35:18] == HALT_UPPER) begin
        add_event(EV_DONE, w, 1'b0, '0);
        mode = MODE_HALTED;
      end else begin
        add_event(EV_TEXT_BEGIN, w, 1'b1, '0);
        mode = MODE_TEXT_HEADER;
      end
    end else begin
      add_event(EV_BAD_WORD, w, 1'b0, '0);
      mode = MODE_HALTED;
    end
  endtask

  // Work out the events of one accepted beat and queue them behind the older ones.
  task automatic decode_word(input logic is_end, input logic [WordW-1:0] w);
    draw_event_t e;
    word_events.delete();
    case (mode)
      MODE_DISPATCH: begin
        if (is_end) begin
          add_event(EV_DONE, w, 1'b0, '0);
          mode = MODE_HALTED;
        end else begin
          start_figure(w);
        end
      end
      MODE_LINE: begin
        if (is_end) begin
          add_event(EV_LINE_END, w, 1'b0, '0);
          add_event(EV_DONE, w, 1'b0, '0);
          mode = MODE_HALTED;
        end else if (w[0]) begin
          add_event(EV_LINE_POINT, w, 1'b1, '0);
        end else begin
          add_event(EV_LINE_END, w, 1'b0, '0);
          start_figure(w);
        end
      end
      MODE_TEXT_HEADER, MODE_TEXT_CHARS: begin
        if (is_end) begin
          add_event(EV_TEXT_END, w, 1'b0, '0);
          add_event(EV_DONE, w, 1'b0, '0);
          mode = MODE_HALTED;
        end else if (!w[0]) begin
          add_event(EV_TEXT_END, w, 1'b0, '0);
          start_figure(w);
        end else if (mode == MODE_TEXT_HEADER) begin
          if (w[35:18] != '0) begin
            add_event(EV_NOT_TEXT, w, 1'b0, '0);
            mode = MODE_HALTED;
          end else begin
            mode = MODE_TEXT_CHARS;
          end
        end else begin
          // High field first; skip zero codes.
          for (int k = 0; k < NChars; k++) begin
            if (w[35 - CharW * k -: CharW] != '0)
              add_event(EV_CHAR, w, 1'b0, w[35 - CharW * k -: CharW]);
          end
        end
      end
      default: mode = MODE_HALTED;
    endcase
    if (word_events.size() > 0) begin
      e = word_events.pop_back();
      e.last = 1'b1;
      word_events.push_back(e);
    end
    foreach (word_events[i]) expected_events.push_back(word_events[i]);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    draw_event_t want;
    if (!rst_n) begin
      mode = MODE_DISPATCH;
      expected_events.delete();
    end else begin
      if (in_valid && !in_stall)
        decode_word(in_kind, in_plot_word);
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: event %0d (x %0d, y %0d, char %0d, last %0b) with none expected",
                   $time, out_event_res, out_x_pos, out_y_pos, out_character, out_last);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event", want.ev, out_event_res);
          check_field("x_pos", $signed(want.x), out_x_pos);
          check_field("y_pos", $signed(want.y), out_y_pos);
          check_field("character", want.ch, out_character);
          check_field("last", want.last, out_last);
        end
      end
      if (end_of_test && !tail_reported) begin
        tail_reported = 1'b1;
        if (expected_events.size() != 0) begin
          $display("%0t: %0d events never arrived, oldest is event %0d",
                   $time, expected_events.size(), expected_events[0].ev);
          error_count += expected_events.size();
        end
      end
    end
    events_pending = expected_events.size();
  end

endmodule

[verif/tb_plot_word_stream_decoder.sv]
`timescale 1ns / 1ps
// Testbench top for the plot word stream decoder: stimulus, flow pacing and verdict.
module tb_plot_word_stream_decoder;
  import pwsd_pkg::*;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam logic [PosW-1:0] POS_MIN = 17'h10000;
  localparam logic [PosW-1:0] POS_MAX = 17'h0FFFF;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_ITEMS = 50;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic [35:0]        in_plot_word;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         out_event_res;
  logic signed [16:0] out_x_pos;
  logic signed [16:0] out_y_pos;
  logic [6:0]         out_character;
  logic               out_last;
  logic               end_of_test;
  int                 error_count;
  int                 events_pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int items_sent     = 0;
  int send_pct_tbl[4]  = '{0, 47, 0, 29};
  int stall_pct_tbl[4] = '{0, 0, 47, 29};

  plot_word_stream_decoder u_dut (.*);

  pwsd_event_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [PosW-1:0] rand_pos();
    case ($urandom_range(7))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return '0;
      3: return '1;
      default: return PosW'($urandom);
    endcase
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] line_word(input logic [PosW-1:0] x,
                                                 input logic [PosW-1:0] y);
    return {x, 1'b0, y, 1'b0};
  endfunction

  function automatic logic [WordW-1:0] text_word(input logic [PosW-1:0] x,
                                                 input logic [PosW-1:0] y);
    return {x, 1'b1, y, 1'b0};
  endfunction

  function automatic logic [WordW-1:0] point_word(input logic [PosW-1:0] x,
                                                  input logic [PosW-1:0] y, input logic mid);
    return {x, mid, y, 1'b1};
  endfunction

  function automatic logic [WordW-1:0] header_word(input logic [PosW-1:0] low);
    return {18'd0, low, 1'b1};
  endfunction

  function automatic logic [WordW-1:0] rand_char_word();
    logic [NChars-1:0][CharW-1:0] codes;
    if ($urandom_range(7) == 0)
      return header_word('0);
    for (int k = 0; k < NChars; k++)
      codes[k] = ($urandom_range(3) == 0) ? '0 : CharW'($urandom);
    return {codes, 1'b1};
  endfunction

  // Offer one beat; hold it until accepted.
  task automatic send_item(input logic kind, input logic [WordW-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_plot_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, let every expected event drain, then switch pacing.
  task automatic start_phase(input int send_pct, input int stall_pct, input bit hold);
    in_valid <= 1'b0;
    do @(negedge clk); while (events_pending != 0);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    hold_req       = hold;
    @(posedge clk);
  endtask

  task automatic send_figure();
    int n;
    logic [PosW-1:0] tx;
    if ($urandom_range(1)) begin
      send_item(KIND_WORD, line_word(rand_pos(), rand_pos()));
      n = $urandom_range(6);
      repeat (n) send_item(KIND_WORD, point_word(rand_pos(), rand_pos(), 1'($urandom)));
    end else begin
      // Text at the lowest x is the halt mark; keep it out of the random body.
      do tx = rand_pos(); while (tx == POS_MIN);
      send_item(KIND_WORD, text_word(tx, rand_pos()));
      if ($urandom_range(9) != 0) begin
        send_item(KIND_WORD, header_word(PosW'($urandom)));
        n = $urandom_range(4);
        repeat (n) send_item(KIND_WORD, rand_char_word());
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= KIND_WORD;
    in_plot_word <= '0;
    end_of_test  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_WORD, line_word(POS_MIN, POS_MAX));
    send_item(KIND_WORD, point_word(POS_MAX, POS_MIN, 1'b0));
    send_item(KIND_WORD, point_word('1, '1, 1'b1));
    send_item(KIND_WORD, point_word('0, '0, 1'b0));
    send_item(KIND_WORD, text_word('0, '0));
    send_item(KIND_WORD, header_word('1));
    send_item(KIND_WORD, {7'h7F, 7'h00, 7'h01, 7'h40, 7'h00, 1'b1});
    send_item(KIND_WORD, header_word('0));
    send_item(KIND_WORD, '1);
    send_item(KIND_WORD, text_word(17'h10001, '1));
    send_item(KIND_WORD, header_word('0));
    send_item(KIND_WORD, {7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 1'b1});
    send_item(KIND_WORD, line_word(POS_MAX, POS_MIN));
    send_item(KIND_WORD, text_word('1, POS_MAX));
    send_item(KIND_WORD, line_word('0, '0));
    send_item(KIND_WORD, point_word(PosW'($urandom), PosW'($urandom), 1'b1));

    for (int p = 0; p < 4; p++) begin
      start_phase(send_pct_tbl[p], stall_pct_tbl[p], p == 0);
      while (items_sent < 16 + PHASE_ITEMS * (p + 1)) send_figure();
    end

    // Close the run with one of the stopping cases; the block stays halted after it.
    case ($urandom_range(4))
      0: begin
        send_item(KIND_WORD, line_word(rand_pos(), rand_pos()));
        send_item(KIND_WORD, point_word(rand_pos(), rand_pos(), 1'($urandom)));
        send_item(KIND_END, rand_word());
      end
      1: begin
        send_item(KIND_WORD, text_word(POS_MAX, rand_pos()));
        send_item(KIND_END, rand_word());
      end
      2: begin
        send_item(KIND_WORD, text_word('0, rand_pos()));
        send_item(KIND_WORD, header_word(PosW'($urandom)));
        send_item(KIND_WORD, rand_char_word());
        send_item(KIND_END, rand_word());
      end
      3: begin
        send_item(KIND_WORD, text_word('1, rand_pos()));
        send_item(KIND_WORD, {18'($urandom_range(1, 18'h3FFFF)), PosW'($urandom), 1'b1});
      end
      default: send_item(KIND_WORD, {POS_MIN, 1'b1, PosW'($urandom), 1'b0});
    endcase
    repeat (8) send_item(1'($urandom), rand_word());

    in_valid <= 1'b0;
    do @(negedge clk); while (events_pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pwsd_pkg.sv
hw/rtl/pwsd_front.sv
hw/rtl/pwsd_queue.sv
hw/rtl/pwsd_back.sv
hw/rtl/plot_word_stream_decoder.sv
hw/rtl/pwsd_checker.sv
verif/pwsd_event_checker.sv
verif/tb_plot_word_stream_decoder.sv
